/* src/uhb_pkg.sv */
// ----------------------------------------------------------------------------
// UDP/IPv4 header builder package
// Shared widths, register indexes, header constants and bundled types.
// ----------------------------------------------------------------------------
package uhb_pkg;

  localparam int MAC_W     = 48;
  localparam int IP_W      = 32;
  localparam int PORT_W    = 16;
  localparam int LEN_W     = 16;
  localparam int WORD_W    = 16;
  localparam int IDX_W     = 5;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 48;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_MAC  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GATEWAY_MAC = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_IP   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_PORT = 3'd3;

  // Header constants.
  localparam logic [LEN_W-1:0]  MAX_PAYLOAD   = 16'd65507;
  localparam logic [LEN_W-1:0]  IP_UDP_BYTES  = 16'd28;
  localparam logic [LEN_W-1:0]  UDP_HDR_BYTES = 16'd8;
  localparam logic [WORD_W-1:0] ETH_TYPE_IPV4 = 16'h0800;
  localparam logic [WORD_W-1:0] IP_VER_IHL    = 16'h4500;
  localparam logic [WORD_W-1:0] IP_FLAGS_DF   = 16'h4000;
  localparam logic [WORD_W-1:0] IP_TTL_PROTO  = 16'h4011;

  // Word positions within the 42-byte header.
  localparam logic [IDX_W-1:0] W_GW_MAC_HI  = 5'd0;
  localparam logic [IDX_W-1:0] W_GW_MAC_MID = 5'd1;
  localparam logic [IDX_W-1:0] W_GW_MAC_LO  = 5'd2;
  localparam logic [IDX_W-1:0] W_SRC_MAC_HI = 5'd3;
  localparam logic [IDX_W-1:0] W_SRC_MAC_MD = 5'd4;
  localparam logic [IDX_W-1:0] W_SRC_MAC_LO = 5'd5;
  localparam logic [IDX_W-1:0] W_ETH_TYPE   = 5'd6;
  localparam logic [IDX_W-1:0] W_VER_IHL    = 5'd7;
  localparam logic [IDX_W-1:0] W_TOT_LEN    = 5'd8;
  localparam logic [IDX_W-1:0] W_IP_ID      = 5'd9;
  localparam logic [IDX_W-1:0] W_FLAGS      = 5'd10;
  localparam logic [IDX_W-1:0] W_TTL_PROTO  = 5'd11;
  localparam logic [IDX_W-1:0] W_IP_CSUM    = 5'd12;
  localparam logic [IDX_W-1:0] W_SRC_IP_HI  = 5'd13;
  localparam logic [IDX_W-1:0] W_SRC_IP_LO  = 5'd14;
  localparam logic [IDX_W-1:0] W_DST_IP_HI  = 5'd15;
  localparam logic [IDX_W-1:0] W_DST_IP_LO  = 5'd16;
  localparam logic [IDX_W-1:0] W_SRC_PORT   = 5'd17;
  localparam logic [IDX_W-1:0] W_DST_PORT   = 5'd18;
  localparam logic [IDX_W-1:0] W_UDP_LEN    = 5'd19;
  localparam logic [IDX_W-1:0] W_UDP_CSUM   = 5'd20;
  localparam logic [IDX_W-1:0] LAST_WORD    = W_UDP_CSUM;

  typedef struct packed {
    logic [MAC_W-1:0]  source_mac;
    logic [MAC_W-1:0]  gateway_mac;
    logic [IP_W-1:0]   source_ip;
    logic [PORT_W-1:0] source_port;
  } cfg_t;

  typedef struct packed {
    logic [IP_W-1:0]   dest_ip;
    logic [PORT_W-1:0] dest_port;
    logic [LEN_W-1:0]  ip_len;
    logic [LEN_W-1:0]  udp_len;
    logic [WORD_W-1:0] csum;
  } job_t;

endpackage

/* src/uhb_req.sv */
// ----------------------------------------------------------------------------
// UDP/IPv4 header builder request stage
// Saturates the length, computes lengths and the IPv4 checksum, holds the job.
// ----------------------------------------------------------------------------
module uhb_req (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [uhb_pkg::IP_W-1:0]    in_dest_ip,
  input  logic [uhb_pkg::PORT_W-1:0]  in_dest_port,
  input  logic [uhb_pkg::LEN_W-1:0]   in_payload_length,
  input  uhb_pkg::cfg_t               cfg,
  input  logic                        job_pop,
  output logic                        job_valid,
  output uhb_pkg::job_t               job
);
  import uhb_pkg::*;

  logic              job_valid_r;
  logic              job_valid_nxt;
  job_t              job_r;
  job_t              job_nxt;
  logic [LEN_W-1:0]  plen_sat;
  logic [18:0]       sum_raw;
  logic [16:0]       sum_fold1;
  logic [WORD_W-1:0] sum_fold2;
  logic              accept;

  assign in_ready = !job_valid_r || job_pop;
  assign accept   = in_valid && in_ready;

  always_comb begin
    plen_sat = (in_payload_length > MAX_PAYLOAD) ? MAX_PAYLOAD : in_payload_length;
    job_nxt.dest_ip   = in_dest_ip;
    job_nxt.dest_port = in_dest_port;
    job_nxt.ip_len    = plen_sat + IP_UDP_BYTES;
    job_nxt.udp_len   = plen_sat + UDP_HDR_BYTES;
    // Words 7..16 with the checksum word as zero; ID is zero too.
    sum_raw = 19'(IP_VER_IHL) + 19'(IP_FLAGS_DF) + 19'(IP_TTL_PROTO)
            + 19'(job_nxt.ip_len)
            + 19'(cfg.source_ip[31:16]) + 19'(cfg.source_ip[15:0])
            + 19'(in_dest_ip[31:16]) + 19'(in_dest_ip[15:0]);
    sum_fold1 = 17'(sum_raw[15:0]) + 17'(sum_raw[18:16]);
    sum_fold2 = sum_fold1[15:0] + 16'(sum_fold1[16]);
    job_nxt.csum = ~sum_fold2;
  end

  always_comb begin
    job_valid_nxt = job_valid_r;
    if (accept) begin
      job_valid_nxt = 1'b1;
    end else if (job_pop) begin
      job_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      job_valid_r <= 1'b0;
    end else begin
      job_valid_r <= job_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      job_r <= job_nxt;
    end
  end

  assign job_valid = job_valid_r;
  assign job       = job_r;

endmodule

/* src/uhb_ser.sv */
// ----------------------------------------------------------------------------
// UDP/IPv4 header builder serializer
// Steps through the 21 header words of a job into the output register.
// ----------------------------------------------------------------------------
module uhb_ser (
  input  logic                        clk,
  input  logic                        rst_n,
  input  uhb_pkg::cfg_t               cfg,
  input  logic                        job_valid,
  input  uhb_pkg::job_t               job,
  output logic                        job_pop,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [uhb_pkg::WORD_W-1:0]  out_header_word,
  output logic [uhb_pkg::IDX_W-1:0]   out_word_index,
  output logic                        out_last_word
);
  import uhb_pkg::*;

  logic [IDX_W-1:0]  cnt_r;
  logic [IDX_W-1:0]  cnt_nxt;
  logic              out_valid_r;
  logic              out_valid_nxt;
  logic [WORD_W-1:0] word_r;
  logic [WORD_W-1:0] word_nxt;
  logic [IDX_W-1:0]  idx_r;
  logic              last_r;
  logic              load;
  logic              advance;

  assign load    = !out_valid_r || out_ready;
  assign advance = load && job_valid;
  assign job_pop = advance && (cnt_r == LAST_WORD);

  always_comb begin
    case (cnt_r)
      W_GW_MAC_HI:  word_nxt = cfg.gateway_mac[47:32];
      W_GW_MAC_MID: word_nxt = cfg.gateway_mac[31:16];
      W_GW_MAC_LO:  word_nxt = cfg.gateway_mac[15:0];
      W_SRC_MAC_HI: word_nxt = cfg.source_mac[47:32];
      W_SRC_MAC_MD: word_nxt = cfg.source_mac[31:16];
      W_SRC_MAC_LO: word_nxt = cfg.source_mac[15:0];
      W_ETH_TYPE:   word_nxt = ETH_TYPE_IPV4;
      W_VER_IHL:    word_nxt = IP_VER_IHL;
      W_TOT_LEN:    word_nxt = job.ip_len;
      W_IP_ID:      word_nxt = '0;
      W_FLAGS:      word_nxt = IP_FLAGS_DF;
      W_TTL_PROTO:  word_nxt = IP_TTL_PROTO;
      W_IP_CSUM:    word_nxt = job.csum;
      W_SRC_IP_HI:  word_nxt = cfg.source_ip[31:16];
      W_SRC_IP_LO:  word_nxt = cfg.source_ip[15:0];
      W_DST_IP_HI:  word_nxt = job.dest_ip[31:16];
      W_DST_IP_LO:  word_nxt = job.dest_ip[15:0];
      W_SRC_PORT:   word_nxt = cfg.source_port;
      W_DST_PORT:   word_nxt = job.dest_port;
      W_UDP_LEN:    word_nxt = job.udp_len;
      W_UDP_CSUM:   word_nxt = '0;
      default:      word_nxt = '0;
    endcase
  end

  always_comb begin
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r;
    if (advance) begin
      out_valid_nxt = 1'b1;
      cnt_nxt       = (cnt_r == LAST_WORD) ? '0 : cnt_r + 1'b1;
    end else if (load) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      word_r <= word_nxt;
      idx_r  <= cnt_r;
      last_r <= (cnt_r == LAST_WORD);
    end
  end

  assign out_valid       = out_valid_r;
  assign out_header_word = word_r;
  assign out_word_index  = idx_r;
  assign out_last_word   = last_r;

endmodule

/* src/udp_ipv4_header_builder_unit.sv */
// ----------------------------------------------------------------------------
// UDP/IPv4 header builder
// Turns each request into a 42-byte Ethernet/IPv4/UDP header, 16 bits a beat.
// ----------------------------------------------------------------------------
// Usage: the configuration channel (cfg_valid/cfg_ready, cfg_index, cfg_data)
// sets the source MAC, gateway MAC, source IP and source port. It is always
// ready; writes to an index above 3 are dropped. Write it only while idle.
// Each request transaction on the input channel (dest IP, dest port, payload
// length) produces 21 result transactions on the output channel, words 0..20
// in order, with out_last_word set on word 20 (the zero UDP checksum).
// Payload lengths above 65507 are clamped so both length fields stay legal.
// A request passes through the request register, then the output register,
// before its first word is valid. Words leave at one word per cycle while
// the receiver is ready, from the single 16-bit output register. The
// request register takes the next transaction in the cycle the last word of
// the current one is loaded, so back-to-back requests stream without gaps.
// When the receiver stalls, the output register holds its word, the
// serializer stops, and in_ready stays low until the last word of the held
// request is loaded. Reset clears all valid state and the configuration
// registers to zero.
// ----------------------------------------------------------------------------
module udp_ipv4_header_builder_unit (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [uhb_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [uhb_pkg::CFG_DAT_W-1:0]  cfg_data,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [uhb_pkg::IP_W-1:0]       in_dest_ip,
  input  logic [uhb_pkg::PORT_W-1:0]     in_dest_port,
  input  logic [uhb_pkg::LEN_W-1:0]      in_payload_length,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [uhb_pkg::WORD_W-1:0]     out_header_word,
  output logic [uhb_pkg::IDX_W-1:0]      out_word_index,
  output logic                           out_last_word
);
  import uhb_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;
  logic job_valid;
  job_t job;
  logic job_pop;

  // The configuration registers accept a write in every cycle.
  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      case (cfg_index)
        CFG_SOURCE_MAC:  cfg_nxt.source_mac  = cfg_data[MAC_W-1:0];
        CFG_GATEWAY_MAC: cfg_nxt.gateway_mac = cfg_data[MAC_W-1:0];
        CFG_SOURCE_IP:   cfg_nxt.source_ip   = cfg_data[IP_W-1:0];
        CFG_SOURCE_PORT: cfg_nxt.source_port = cfg_data[PORT_W-1:0];
        default:         cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // Request register: length clamp, length fields and IPv4 checksum.
  uhb_req u_req (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_dest_ip        (in_dest_ip),
    .in_dest_port      (in_dest_port),
    .in_payload_length (in_payload_length),
    .cfg               (cfg_r),
    .job_pop           (job_pop),
    .job_valid         (job_valid),
    .job               (job)
  );

  // Word serializer with the output register.
  uhb_ser u_ser (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg             (cfg_r),
    .job_valid       (job_valid),
    .job             (job),
    .job_pop         (job_pop),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_header_word (out_header_word),
    .out_word_index  (out_word_index),
    .out_last_word   (out_last_word)
  );

  // The last flag marks word 20 and nothing else.
  a_last_idx : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_last_word == (out_word_index == LAST_WORD)))
    else $error("last_word does not match word_index");

  // Within a header, taking a word brings the next word in the following cycle.
  a_next_word : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && !out_last_word)
      |=> (out_valid && (out_word_index == $past(out_word_index) + 1'b1)))
    else $error("header words not contiguous");

  // An accepted request is held until the serializer loads its last word.
  a_req_held : assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> job_valid)
    else $error("accepted request lost");

  // A request is released only when the serializer loads word 20.
  a_pop_last : assert property (@(posedge clk) disable iff (!rst_n)
    job_pop |=> (out_valid && out_last_word))
    else $error("request released before its last word");

endmodule
